### rtl/srr_pkg.sv
// Shared constants, codes and controller/datapath interface types for the receiver.
package srr_pkg;

  // Defaults for the top-level parameters
  localparam int SEQ_SPACE_DEF    = 8;
  localparam int WINDOW_SIZE_DEF  = 4;
  localparam int PAYLOAD_BITS_DEF = 32;

  // Fixed field widths on the stream ports
  localparam int SEQ_W       = 3;
  localparam int DATA_W      = 32;
  localparam int IN_TDATA_W  = 40;   // seq_num + payload, rounded up to bytes
  localparam int OUT_TDATA_W = 40;   // delivered_data + ack_num, rounded up to bytes

  // Result kind codes (out_tuser)
  localparam logic KIND_DELIVER = 1'b0;
  localparam logic KIND_REACK   = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;   // latch the incoming request
    logic store;     // write the captured payload into its window slot
    logic reack;     // load a re-ack result into the output register
    logic deliver;   // load the head slot as a result and slide the window
  } srr_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic ok;           // captured request passed its checksum
    logic in_win;       // captured sequence number lies inside the window
    logic head_filled;  // slot at the window base holds data
    logic next_filled;  // slot after the base holds data
    logic out_free;     // output register can take a result this cycle
  } srr_sts_t;

endpackage

### rtl/srr_ctrl.sv
// Sequencing state machine of the receiver: accept, evaluate, drain in-order slots.
module srr_ctrl import srr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  srr_sts_t sts,
  output srr_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_EVAL  = 3'b010,
    ST_DRAIN = 3'b100
  } srr_state_t;

  srr_state_t state_r, state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.capture = in_tvalid && in_tready;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.capture) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (!sts.ok) begin
          state_nxt = ST_IDLE;
        end else if (!sts.in_win) begin
          if (sts.out_free) begin
            cmd.reack = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          cmd.store = 1'b1;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.head_filled) begin
          state_nxt = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.deliver = 1'b1;
          if (!sts.next_filled) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.store, cmd.reack, cmd.deliver}))
    else $error("srr_ctrl: more than one datapath command at once");

  a_capture_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> state_r == ST_EVAL)
    else $error("srr_ctrl: captured request not evaluated");

  a_store_to_drain: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store |=> state_r == ST_DRAIN)
    else $error("srr_ctrl: stored slot not followed by drain");

endmodule

### rtl/srr_dp.sv
// Datapath: request capture, window math, slot storage and output register.
module srr_dp import srr_pkg::*; #(
  parameter int SEQ_SPACE    = SEQ_SPACE_DEF,
  parameter int WINDOW_SIZE  = WINDOW_SIZE_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [SEQ_W-1:0]  in_seq,
  input  logic [DATA_W-1:0] in_payload,
  input  logic              in_ok,
  input  srr_cmd_t          cmd,
  output srr_sts_t          sts,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_kind,
  output logic [DATA_W-1:0] out_data,
  output logic [SEQ_W-1:0]  out_ack,
  output logic              out_last
);

  localparam int BW = $clog2(SEQ_SPACE);
  localparam int SW = ((BW > SEQ_W) ? BW : SEQ_W) + 1;
  localparam int DW = (PAYLOAD_BITS < DATA_W) ? PAYLOAD_BITS : DATA_W;

  // Captured request
  logic [SEQ_W-1:0] seq_r;
  logic [DW-1:0]    data_r;
  logic             ok_r;

  // Window state
  logic [BW-1:0] base_r, base_nxt;
  logic          filled_r [WINDOW_SIZE];
  logic          filled_nxt [WINDOW_SIZE];
  logic [DW-1:0] slot_r [WINDOW_SIZE];
  logic [DW-1:0] slot_nxt [WINDOW_SIZE];

  // Output register
  logic              ovalid_r, ovalid_nxt;
  logic              kind_r;
  logic [DATA_W-1:0] odata_r;
  logic [SEQ_W-1:0]  ack_r;
  logic              last_r;

  logic [SW-1:0] seq_m, base_e, offset;
  logic          in_win;
  logic          next_filled;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      seq_r  <= in_seq;
      data_r <= in_payload[DW-1:0];
      ok_r   <= in_ok;
    end
  end

  // Reduce the sequence number into the sequence space, then distance from the base
  always_comb begin
    seq_m = SW'(seq_r);
    for (int i = 0; i < 4; i++) begin
      if (seq_m >= SW'(SEQ_SPACE)) begin
        seq_m = seq_m - SW'(SEQ_SPACE);
      end
    end
    base_e = SW'(base_r);
    if (seq_m >= base_e) begin
      offset = seq_m - base_e;
    end else begin
      offset = seq_m + SW'(SEQ_SPACE) - base_e;
    end
    in_win = (32'(offset) < 32'(WINDOW_SIZE));
  end

  generate
    if (WINDOW_SIZE > 1) begin : g_next
      assign next_filled = filled_r[1];
    end else begin : g_single
      assign next_filled = 1'b0;
    end
  endgenerate

  // Store at the offset slot, or shift the window down by one on delivery
  always_comb begin
    filled_nxt = filled_r;
    slot_nxt   = slot_r;
    base_nxt   = base_r;
    if (cmd.store) begin
      for (int i = 0; i < WINDOW_SIZE; i++) begin
        if (32'(offset) == 32'(i)) begin
          filled_nxt[i] = 1'b1;
          slot_nxt[i]   = data_r;
        end
      end
    end else if (cmd.deliver) begin
      for (int i = 0; i < WINDOW_SIZE - 1; i++) begin
        filled_nxt[i] = filled_r[i+1];
        slot_nxt[i]   = slot_r[i+1];
      end
      filled_nxt[WINDOW_SIZE-1] = 1'b0;
      base_nxt = (base_r == BW'(SEQ_SPACE - 1)) ? '0 : base_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      for (int i = 0; i < WINDOW_SIZE; i++) begin
        filled_r[i] <= 1'b0;
      end
    end else begin
      base_r   <= base_nxt;
      filled_r <= filled_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  // Output register: a new result may load in the cycle the old one is taken
  assign sts.out_free = !ovalid_r || out_ready;

  always_comb begin
    ovalid_nxt = ovalid_r;
    if (out_ready) begin
      ovalid_nxt = 1'b0;
    end
    if (cmd.reack || cmd.deliver) begin
      ovalid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else begin
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.reack) begin
      kind_r  <= KIND_REACK;
      odata_r <= '0;
      ack_r   <= seq_r;
      last_r  <= 1'b1;
    end else if (cmd.deliver) begin
      kind_r  <= KIND_DELIVER;
      odata_r <= DATA_W'(slot_r[0]);
      ack_r   <= SEQ_W'(base_r);
      last_r  <= !next_filled;
    end
  end

  assign sts.ok          = ok_r;
  assign sts.in_win      = in_win;
  assign sts.head_filled = filled_r[0];
  assign sts.next_filled = next_filled;

  assign out_valid = ovalid_r;
  assign out_kind  = kind_r;
  assign out_data  = odata_r;
  assign out_ack   = ack_r;
  assign out_last  = last_r;

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.reack || cmd.deliver) |-> sts.out_free)
    else $error("srr_dp: result loaded over an untaken result");

  a_deliver_head: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.deliver |-> filled_r[0])
    else $error("srr_dp: delivery from an empty head slot");

  a_base_slides: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.deliver |=> base_r != $past(base_r))
    else $error("srr_dp: window base did not advance on delivery");

endmodule

### rtl/selective_repeat_receiver.sv
// Top level of the selective-repeat receive window: stream ports, controller, datapath.
//
// Usage:
//   Input stream (in_*): one request per packet. in_tdata carries the sequence
//   number and the payload, in_tuser the checksum-good flag from the checker
//   upstream. Corrupt requests are dropped without a result.
//   Output stream (out_*): acknowledgements. out_tuser = 0 marks an in-order
//   delivery (payload plus ack of its number), out_tuser = 1 a re-ack of a good
//   packet that fell outside the window (payload field zero). out_tlast marks
//   the final result caused by one input request.
//   Timing: one request at a time. A request is captured, then evaluated: a
//   corrupt one is dropped, a re-ack is loaded, or the payload is stored and
//   in-order slots drain from the window shift register head, one delivery
//   per cycle while the output register is free. in_tready is low while a
//   request is worked on. Results sit in an output register; a new result
//   loads in the same cycle the previous one is taken, so a stall on out_tready
//   holds the drain sequencer until the consumer catches up, and nothing is lost.
//   Reset (rst_n low, synchronous): window base to zero, all slots empty,
//   output register empty. Slot payloads are not cleared; an empty slot is
//   never read.
module selective_repeat_receiver import srr_pkg::*; #(
  parameter int SEQ_SPACE    = SEQ_SPACE_DEF,
  parameter int WINDOW_SIZE  = WINDOW_SIZE_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [2:0] seq_num, [34:3] payload, rest zero
  input  logic                   in_tuser,   // [0] checksum_ok
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [31:0] delivered_data, [34:32] ack_num, rest zero
  output logic                   out_tuser,  // [0] kind
  output logic                   out_tlast
);

  srr_cmd_t cmd;
  srr_sts_t sts;

  logic [DATA_W-1:0] out_data;
  logic [SEQ_W-1:0]  out_ack;

  // Sequencer: accept a request, evaluate it, then drain the in-order slots
  srr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Window storage and result formatting
  srr_dp #(
    .SEQ_SPACE    (SEQ_SPACE),
    .WINDOW_SIZE  (WINDOW_SIZE),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_seq     (in_tdata[SEQ_W-1:0]),
    .in_payload (in_tdata[SEQ_W+DATA_W-1:SEQ_W]),
    .in_ok      (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_kind   (out_tuser),
    .out_data   (out_data),
    .out_ack    (out_ack),
    .out_last   (out_tlast)
  );

  // Pack the result; pad bits up to the byte boundary stay zero
  assign out_tdata = {{(OUT_TDATA_W - DATA_W - SEQ_W){1'b0}}, out_ack, out_data};

endmodule

### tb/selective_repeat_receiver_tb.sv
// Self-checking testbench for the selective-repeat receive window, stream ports on both sides.
module selective_repeat_receiver_tb import srr_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN          = WINDOW_SIZE_DEF;
  localparam int HOLD_CYCLES  = 400;     // long consumer hold-off
  localparam int LIMIT_CYCLES = 150000;  // abort limit for a hung run
  localparam int DRAIN_CYCLES = 20;      // extra wait for stray results after the drain

  // One expected acknowledgement as it should leave the block
  typedef struct packed {
    logic              kind;
    logic [DATA_W-1:0] data;
    logic [SEQ_W-1:0]  ack;
    logic              last;
  } ack_rec_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [2:0] seq_num, [34:3] payload, rest zero
  logic                   in_tuser = 1'b0; // [0] checksum_ok
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // [31:0] delivered_data, [34:32] ack_num, rest zero
  logic                   out_tuser;       // [0] kind
  logic                   out_tlast;

  // Shadow of the receive window, updated on every accepted request
  logic [SEQ_W-1:0]  win_base;
  logic              slot_full [WIN];
  logic [DATA_W-1:0] slot_val  [WIN];

  ack_rec_t awaited_acks[$];
  int       mismatches = 0;
  int       cycle_count = 0;

  // Idle control shared by both sides; one long hold-off on the consumer
  bit gaps_on = 1'b1;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  selective_repeat_receiver u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Apply one accepted request to the shadow window and queue what it releases.
  task automatic apply_packet(input logic [SEQ_W-1:0] seq, input logic [DATA_W-1:0] pay,
                              input logic ok);
    logic [SEQ_W-1:0] offset;
    ack_rec_t         rec;
    if (!ok) return;  // corrupt: drop silently, window untouched
    // Sequence space is a power of two, so 3-bit subtraction wraps for us
    offset = seq - win_base;
    if (offset >= WIN) begin
      rec.kind = KIND_REACK;
      rec.data = '0;
      rec.ack  = seq;
      rec.last = 1'b1;
      awaited_acks.push_back(rec);
      return;
    end
    slot_full[offset] = 1'b1;
    slot_val[offset]  = pay;  // a duplicate simply overwrites
    // Drain consecutive filled slots from the base; the final one carries last
    while (slot_full[0]) begin
      rec.kind = KIND_DELIVER;
      rec.data = slot_val[0];
      rec.ack  = win_base;
      rec.last = !slot_full[1];
      awaited_acks.push_back(rec);
      win_base = win_base + 1'b1;
      for (int i = 0; i + 1 < WIN; i++) begin
        slot_full[i] = slot_full[i+1];
        slot_val[i]  = slot_val[i+1];
      end
      slot_full[WIN-1] = 1'b0;
    end
  endtask

  // Offer one request, hold it until taken, then maybe idle for a while.
  task automatic send_packet(input logic [SEQ_W-1:0] seq, input logic [DATA_W-1:0] pay,
                             input logic ok);
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - SEQ_W - DATA_W){1'b0}}, pay, seq};
    in_tuser  <= ok;
    do @(posedge clk); while (!in_tready);
    apply_packet(seq, pay, ok);
    if (gaps_on && $urandom_range(0, 99) < 22) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Pick a request from the current window position: mostly in-window traffic,
  // some stale or far-ahead good packets, some corrupt ones.
  task automatic send_random();
    logic [SEQ_W-1:0] seq;
    int               pick;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      seq = SEQ_W'($urandom_range(0, 7));
      send_packet(seq, $urandom, 1'b0);
    end else if (pick < 25) begin
      seq = win_base + SEQ_W'($urandom_range(WIN, 7));
      send_packet(seq, $urandom, 1'b1);
    end else begin
      seq = win_base + SEQ_W'($urandom_range(0, WIN - 1));
      send_packet(seq, $urandom, 1'b1);
    end
  endtask

  // Stop offering and wait until every queued acknowledgement has arrived.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (awaited_acks.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string fname, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, fname, want, got);
      mismatches++;
    end
  endtask

  // Consumer side: random stalls, plus one long hold-off when a test asks
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      hold_done  <= 1'b1;
    end else begin
      out_tready <= !gaps_on || ($urandom_range(0, 99) >= 22);
    end
  end

  // Compare every accepted result against the oldest queued expectation
  always @(posedge clk) begin : result_check
    ack_rec_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_acks.size() == 0) begin
        $display("%0t: unexpected result, expected none, got kind %b data %h ack %0d last %b",
                 $time, out_tuser, out_tdata[31:0], out_tdata[34:32], out_tlast);
        mismatches++;
      end else begin
        want = awaited_acks.pop_front();
        check_field("kind", DATA_W'(want.kind), DATA_W'(out_tuser));
        check_field("delivered_data", want.data, out_tdata[31:0]);
        check_field("ack_num", DATA_W'(want.ack), DATA_W'(out_tdata[34:32]));
        check_field("last", DATA_W'(want.last), DATA_W'(out_tlast));
      end
    end
  end

  // Corrupt requests anywhere must leave no trace
  task automatic test_corrupt_drop();
    send_packet(3'd0, 32'hFFFF_FFFF, 1'b0);
    send_packet(3'd7, 32'h0000_0000, 1'b0);
  endtask

  // Base-of-window arrivals deliver at once; payload extremes
  task automatic test_in_order();
    send_packet(3'd0, 32'h0000_0000, 1'b1);
    send_packet(3'd1, 32'hFFFF_FFFF, 1'b1);
  endtask

  // Buffer ahead of the base, overwrite a duplicate, then release a full window
  task automatic test_out_of_order();
    send_packet(3'd5, 32'hA5A5_A5A5, 1'b1);
    send_packet(3'd4, 32'h1111_1111, 1'b1);
    send_packet(3'd3, 32'h5A5A_5A5A, 1'b1);
    send_packet(3'd4, 32'h8000_0001, 1'b1);
    send_packet(3'd2, 32'h7FFF_FFFE, 1'b1);
  endtask

  // Good packets outside the window: stale ones and ones too far ahead
  task automatic test_reack();
    send_packet(3'd5, 32'hFFFF_FFFF, 1'b1);
    send_packet(3'd2, 32'hFFFF_FFFF, 1'b1);
    send_packet(3'd3, 32'h1234_5678, 1'b1);
  endtask

  // Window spanning the wrap from 7 to 0, released in one burst
  task automatic test_wrap();
    send_packet(3'd7, 32'hDEAD_BEEF, 1'b1);
    send_packet(3'd0, 32'h0F0F_0F0F, 1'b1);
    send_packet(3'd1, 32'hF0F0_F0F0, 1'b1);
    send_packet(3'd6, 32'hCAFE_F00D, 1'b1);
    send_packet(3'd2, 32'h0000_0001, 1'b0);
    send_packet(3'd2, 32'h0000_0002, 1'b1);
    send_packet(3'd7, 32'h0000_0003, 1'b1);
  endtask

  // Hold the consumer off while the producer keeps pushing in-order traffic
  task automatic test_backpressure();
    hold_req <= 1'b1;
    repeat (40) begin
      if ($urandom_range(0, 3) != 0)
        send_packet(win_base, $urandom, 1'b1);
      else
        send_random();
    end
    wait_drained();
  endtask

  // Back-to-back traffic with no idling on either side
  task automatic test_no_idle();
    gaps_on <= 1'b0;
    repeat (60) send_random();
    gaps_on <= 1'b1;
  endtask

  task automatic test_random();
    repeat (230) send_random();
  endtask

  initial begin
    win_base = '0;
    for (int i = 0; i < WIN; i++) begin
      slot_full[i] = 1'b0;
      slot_val[i]  = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_corrupt_drop();
    test_in_order();
    test_out_of_order();
    test_reack();
    test_wrap();
    wait_drained();
    test_backpressure();
    test_no_idle();
    test_random();

    // Let the last burst drain, then keep watching for stray results
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaited_acks.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
